@@ rtl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    // default parameter values
    localparam int STACK_LIMIT_DEF = 16;
    localparam int POS_BITS_DEF    = 16;

    // depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // result field widths
    localparam int STATUS_W = 3;
    localparam int ERRPOS_W = 16;

    // character codes of interest
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // bracket kinds as kept on the stack
    localparam logic [1:0] KIND_PAREN   = 2'd0;
    localparam logic [1:0] KIND_BRACKET = 2'd1;
    localparam logic [1:0] KIND_BRACE   = 2'd2;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_SLASH,
        CLS_QUOTE,
        CLS_BACKSLASH,
        CLS_NEWLINE,
        CLS_OPEN,
        CLS_CLOSE
    } cls_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_DEEP     = 3'd2,
        ST_STRING   = 3'd3,
        ST_UNCLOSED = 3'd4
    } status_t;

    // classified character as it travels through the queue
    typedef struct packed {
        logic       last;
        cls_t       cls;
        logic [1:0] kind;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

`default_nettype wire

@@ rtl/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/bbc_queue.sv @@
// ----------------------------------------------------------------------------
// bbc_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bbc_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_front.sv @@
// ----------------------------------------------------------------------------
// bbc_front
// Accepts text bytes, classifies them and tags each with its position.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front #(
    parameter int POS_BITS = bbc_pkg::POS_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          ch,
    input  wire logic                last,
    input  wire logic                valid,
    output logic                     ready,
    input  wire logic                queue_full,
    output logic                     push,
    output bbc_pkg::item_t           item,
    output logic      [POS_BITS-1:0] idx
);

    logic [POS_BITS-1:0] index_reg, index_next;

    assign ready = !queue_full;
    assign push  = valid && ready;
    assign idx   = index_reg;

    always_comb begin
        item.last = last;
        item.kind = bbc_pkg::KIND_PAREN;
        case (ch)
            bbc_pkg::CH_LPAREN: begin
                item.cls = bbc_pkg::CLS_OPEN;
            end
            bbc_pkg::CH_LBRACKET: begin
                item.cls  = bbc_pkg::CLS_OPEN;
                item.kind = bbc_pkg::KIND_BRACKET;
            end
            bbc_pkg::CH_LBRACE: begin
                item.cls  = bbc_pkg::CLS_OPEN;
                item.kind = bbc_pkg::KIND_BRACE;
            end
            bbc_pkg::CH_RPAREN: begin
                item.cls = bbc_pkg::CLS_CLOSE;
            end
            bbc_pkg::CH_RBRACKET: begin
                item.cls  = bbc_pkg::CLS_CLOSE;
                item.kind = bbc_pkg::KIND_BRACKET;
            end
            bbc_pkg::CH_RBRACE: begin
                item.cls  = bbc_pkg::CLS_CLOSE;
                item.kind = bbc_pkg::KIND_BRACE;
            end
            bbc_pkg::CH_QUOTE:     item.cls = bbc_pkg::CLS_QUOTE;
            bbc_pkg::CH_BACKSLASH: item.cls = bbc_pkg::CLS_BACKSLASH;
            bbc_pkg::CH_SPACE:     item.cls = bbc_pkg::CLS_SPACE;
            bbc_pkg::CH_SLASH:     item.cls = bbc_pkg::CLS_SLASH;
            bbc_pkg::CH_NEWLINE:   item.cls = bbc_pkg::CLS_NEWLINE;
            default:               item.cls = bbc_pkg::CLS_OTHER;
        endcase
    end

    // position restarts after the final byte of each text
    always_comb begin
        index_next = index_reg;
        if (push) begin
            index_next = last ? '0 : POS_BITS'(index_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
        end else begin
            index_reg <= index_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_back.sv @@
// ----------------------------------------------------------------------------
// bbc_back
// Runs the string, comment and bracket stack logic and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back #(
    parameter int STACK_LIMIT = bbc_pkg::STACK_LIMIT_DEF,
    parameter int POS_BITS    = bbc_pkg::POS_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           queue_empty,
    input  wire bbc_pkg::item_t                 item,
    input  wire logic [POS_BITS-1:0]            idx,
    output logic                                pop,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic      [bbc_pkg::STATUS_W-1:0]   res_status,
    output logic      [bbc_pkg::ERRPOS_W-1:0]   res_pos
);

    localparam int AW = $clog2(STACK_LIMIT);

    logic [AW-1:0]           depth_reg, depth_next;
    logic                    in_string_reg, in_string_next;
    logic                    bs_odd_reg, bs_odd_next;
    logic                    in_comment_reg, in_comment_next;
    logic                    prev_space_reg, prev_space_next;
    logic [POS_BITS-1:0]     mark_reg, mark_next;
    bbc_pkg::status_t        err_reg, err_next;
    logic [POS_BITS-1:0]     err_idx_reg, err_idx_next;

    // values after this byte, before the end-of-text restart
    logic [AW-1:0]           s_depth;
    logic                    s_in_string, s_bs_odd, s_in_comment, s_prev_space;
    logic [POS_BITS-1:0]     s_mark, s_err_idx;
    bbc_pkg::status_t        s_err;
    bbc_pkg::status_t        fin_err;
    logic [POS_BITS-1:0]     fin_idx;
    logic [POS_BITS+15:0]    fin_wide;

    logic                    out_free;
    logic                    do_push;
    logic [1:0]              top_kind;
    logic [1:0]              ram_rdata;
    logic [AW-1:0]           ram_raddr;
    logic                    bypass_reg;
    logic [1:0]              bypass_kind_reg;
    logic                    res_valid_reg, res_valid_next;
    logic [bbc_pkg::STATUS_W-1:0] res_status_reg;
    logic [bbc_pkg::ERRPOS_W-1:0] res_pos_reg;

    assign out_free = !res_valid_reg || res_ready;
    assign pop      = !queue_empty && (!item.last || out_free);
    assign top_kind = bypass_reg ? bypass_kind_reg : ram_rdata;

    always_comb begin
        s_depth      = depth_reg;
        s_in_string  = in_string_reg;
        s_bs_odd     = bs_odd_reg;
        s_in_comment = in_comment_reg;
        s_prev_space = prev_space_reg;
        s_mark       = mark_reg;
        s_err        = err_reg;
        s_err_idx    = err_idx_reg;
        do_push      = 1'b0;
        if (pop && err_reg == bbc_pkg::ST_OK) begin
            if (in_comment_reg) begin
                if (item.cls == bbc_pkg::CLS_NEWLINE) begin
                    s_in_comment = 1'b0;
                end
            end else if (in_string_reg) begin
                case (item.cls)
                    bbc_pkg::CLS_QUOTE: begin
                        if (!bs_odd_reg) begin
                            s_in_string = 1'b0;
                        end
                        s_bs_odd = 1'b0;
                    end
                    bbc_pkg::CLS_BACKSLASH: s_bs_odd = !bs_odd_reg;
                    default:                s_bs_odd = 1'b0;
                endcase
            end else begin
                s_prev_space = 1'b0;
                if (prev_space_reg && item.cls == bbc_pkg::CLS_SLASH) begin
                    s_in_comment = 1'b1;
                    s_mark       = POS_BITS'(idx - 1'b1);
                end else begin
                    case (item.cls)
                        bbc_pkg::CLS_SPACE: s_prev_space = 1'b1;
                        bbc_pkg::CLS_QUOTE: begin
                            s_in_string = 1'b1;
                            s_bs_odd    = 1'b0;
                            s_mark      = idx;
                        end
                        bbc_pkg::CLS_OPEN: begin
                            if (depth_reg == AW'(STACK_LIMIT - 1)) begin
                                s_err     = bbc_pkg::ST_DEEP;
                                s_err_idx = idx;
                            end else begin
                                do_push = 1'b1;
                                s_depth = AW'(depth_reg + 1'b1);
                            end
                        end
                        bbc_pkg::CLS_CLOSE: begin
                            if (depth_reg == '0 || top_kind != item.kind) begin
                                s_err     = bbc_pkg::ST_MISMATCH;
                                s_err_idx = idx;
                            end else begin
                                s_depth = AW'(depth_reg - 1'b1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // end-of-text checks on the updated state
    always_comb begin
        fin_err = s_err;
        fin_idx = s_err_idx;
        if (s_err == bbc_pkg::ST_OK) begin
            if (s_in_comment) begin
                if (s_depth != '0) begin
                    fin_err = bbc_pkg::ST_UNCLOSED;
                    fin_idx = s_mark;
                end
            end else if (s_in_string) begin
                fin_err = bbc_pkg::ST_STRING;
                fin_idx = s_mark;
            end else if (s_depth != '0) begin
                fin_err = bbc_pkg::ST_UNCLOSED;
                fin_idx = POS_BITS'(idx + 1'b1);
            end
        end
        fin_wide = {16'b0, (fin_err == bbc_pkg::ST_OK) ? '0 : fin_idx};
    end

    always_comb begin
        if (pop && item.last) begin
            depth_next      = '0;
            in_string_next  = 1'b0;
            bs_odd_next     = 1'b0;
            in_comment_next = 1'b0;
            prev_space_next = 1'b0;
            mark_next       = '0;
            err_next        = bbc_pkg::ST_OK;
            err_idx_next    = '0;
        end else begin
            depth_next      = s_depth;
            in_string_next  = s_in_string;
            bs_odd_next     = s_bs_odd;
            in_comment_next = s_in_comment;
            prev_space_next = s_prev_space;
            mark_next       = s_mark;
            err_next        = s_err;
            err_idx_next    = s_err_idx;
        end
        // read ahead the entry that will be on top next cycle
        ram_raddr      = AW'(depth_next - 1'b1);
        res_valid_next = (res_valid_reg && !res_ready) || (pop && item.last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg      <= '0;
            in_string_reg  <= 1'b0;
            bs_odd_reg     <= 1'b0;
            in_comment_reg <= 1'b0;
            prev_space_reg <= 1'b0;
            mark_reg       <= '0;
            err_reg        <= bbc_pkg::ST_OK;
            err_idx_reg    <= '0;
            bypass_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            depth_reg      <= depth_next;
            in_string_reg  <= in_string_next;
            bs_odd_reg     <= bs_odd_next;
            in_comment_reg <= in_comment_next;
            prev_space_reg <= prev_space_next;
            mark_reg       <= mark_next;
            err_reg        <= err_next;
            err_idx_reg    <= err_idx_next;
            bypass_reg     <= do_push;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bypass_kind_reg <= item.kind;
        if (pop && item.last) begin
            res_status_reg <= fin_err;
            res_pos_reg    <= fin_wide[15:0];
        end
    end

    bbc_ram #(
        .WIDTH(2),
        .DEPTH(STACK_LIMIT)
    ) u_stack (
        .aclk  (aclk),
        .we    (do_push),
        .waddr (depth_reg),
        .wdata (item.kind),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_pos    = res_pos_reg;

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streams source text and reports whether its brackets are balanced.
// ----------------------------------------------------------------------------
// one text byte per transfer on the s_ side, s_tlast on the final byte. the
// block takes one byte every clock cycle while its queue has room: a front
// stage classifies each byte and tags it with its position, a four-entry
// queue carries it to the back stage, and the back stage runs string and
// comment tracking and the bracket stack, one byte per cycle but for a final
// byte held for the m_ side. the stack lives in a small ram with registered
// read; the entry that will be on top is read ahead and the byte just pushed
// is bypassed, so pushes and pops follow each other without a bubble. one
// result transfer goes out on the m_ side after each final byte, held in an
// output register; while it waits, later bytes keep flowing, and only the
// next final byte waits. a final byte passes the queue and then the output
// register. the first error in a text is kept; all state restarts per result.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker #(
    parameter int STACK_LIMIT = bbc_pkg::STACK_LIMIT_DEF,   // open brackets allowed + 1
    parameter int POS_BITS    = bbc_pkg::POS_BITS_DEF       // position counter width
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // text input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] ch
    input  wire logic        s_tlast,     // final byte of the text
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata      // [2:0] status, [18:3] err_pos, [23:19] zero
);

    localparam int QW = bbc_pkg::ITEM_W + POS_BITS;

    // front to queue
    logic                 f_push;
    bbc_pkg::item_t       f_item;
    logic [POS_BITS-1:0]  f_idx;
    logic                 q_full;

    // queue to back
    logic [QW-1:0]        q_data;
    logic                 q_empty;
    logic                 b_pop;
    bbc_pkg::item_t       b_item;
    logic [POS_BITS-1:0]  b_idx;

    // result
    logic [bbc_pkg::STATUS_W-1:0] r_status;
    logic [bbc_pkg::ERRPOS_W-1:0] r_pos;

    bbc_front #(
        .POS_BITS(POS_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ch         (s_tdata),
        .last       (s_tlast),
        .valid      (s_tvalid),
        .ready      (s_tready),
        .queue_full (q_full),
        .push       (f_push),
        .item       (f_item),
        .idx        (f_idx)
    );

    bbc_queue #(
        .WIDTH(QW),
        .DEPTH(bbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_idx, f_item}),
        .full      (q_full),
        .pop       (b_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // unpack queue entry: position above the classified item
    assign b_item = bbc_pkg::item_t'(q_data[bbc_pkg::ITEM_W-1:0]);
    assign b_idx  = q_data[QW-1:bbc_pkg::ITEM_W];

    bbc_back #(
        .STACK_LIMIT(STACK_LIMIT),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .item        (b_item),
        .idx         (b_idx),
        .pop         (b_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (r_status),
        .res_pos     (r_pos)
    );

    assign m_tdata = {5'b0, r_pos, r_status};

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams short source texts into the bracket balance checker, one byte per
// transfer, with random gaps on the input side and random stalls on the
// result side. An in-bench tracker of brackets, strings and comments works out
// the verdict of every text, and each result transfer is compared field by
// field against the oldest verdict still due.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STACK_CAP = bbc_pkg::STACK_LIMIT_DEF;

    typedef struct {
        logic [7:0]  ch;
        bit          fin;
        int unsigned gap;
        bit          drain;   // hold this byte back until no verdict is due
    } text_byte_t;

    typedef struct {
        bbc_pkg::status_t status;
        logic [15:0]      pos;
    } text_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    always #4 aclk = ~aclk;

    bracket_balance_checker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    text_byte_t    pending_bytes [$];
    text_verdict_t due_verdicts [$];
    int unsigned   bytes_total;
    int unsigned   bytes_sent;
    int unsigned   texts_queued;
    int unsigned   results_seen;
    int unsigned   hold_at;
    int unsigned   errors;
    bit            gap_style;
    bit            drain_next;

    // ------------------------------------------------------------------------
    // bracket tracker, advanced once per accepted byte
    // ------------------------------------------------------------------------
    logic [1:0]       open_kinds [STACK_CAP];
    int unsigned      depth;
    bit               in_str;
    bit               esc_odd;
    bit               in_cmt;
    bit               after_space;
    logic [15:0]      pos_now = 16'd0;
    logic [15:0]      mark_at = 16'd0;
    bbc_pkg::status_t first_err = bbc_pkg::ST_OK;
    logic [15:0]      err_at = 16'd0;

    function automatic logic [1:0] kind_of(input logic [7:0] c);
        case (c)
            bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN:     return bbc_pkg::KIND_PAREN;
            bbc_pkg::CH_LBRACKET, bbc_pkg::CH_RBRACKET: return bbc_pkg::KIND_BRACKET;
            default:                                    return bbc_pkg::KIND_BRACE;
        endcase
    endfunction

    function automatic void track_char(input logic [7:0] c, input bit fin);
        logic [15:0]   here;
        bit            sp;
        text_verdict_t v;
        here = pos_now;
        if (first_err == bbc_pkg::ST_OK) begin
            if (in_cmt) begin
                // the newline is eaten by the comment
                if (c == bbc_pkg::CH_NEWLINE) in_cmt = 1'b0;
            end else if (in_str) begin
                if (c == bbc_pkg::CH_QUOTE) begin
                    if (!esc_odd) in_str = 1'b0;
                    esc_odd = 1'b0;
                end else if (c == bbc_pkg::CH_BACKSLASH) begin
                    esc_odd = !esc_odd;
                end else begin
                    esc_odd = 1'b0;
                end
            end else begin
                sp = after_space;
                after_space = 1'b0;
                if (sp && c == bbc_pkg::CH_SLASH) begin
                    in_cmt  = 1'b1;
                    mark_at = here - 16'd1;
                end else if (c == bbc_pkg::CH_SPACE) begin
                    after_space = 1'b1;
                end else if (c == bbc_pkg::CH_QUOTE) begin
                    in_str  = 1'b1;
                    esc_odd = 1'b0;
                    mark_at = here;
                end else begin
                    case (c)
                        bbc_pkg::CH_LPAREN, bbc_pkg::CH_LBRACKET,
                        bbc_pkg::CH_LBRACE: begin
                            if (depth + 1 >= STACK_CAP) begin
                                first_err = bbc_pkg::ST_DEEP;
                                err_at    = here;
                            end else begin
                                open_kinds[depth] = kind_of(c);
                                depth++;
                            end
                        end
                        bbc_pkg::CH_RPAREN, bbc_pkg::CH_RBRACKET,
                        bbc_pkg::CH_RBRACE: begin
                            if (depth == 0 || open_kinds[depth-1] != kind_of(c)) begin
                                first_err = bbc_pkg::ST_MISMATCH;
                                err_at    = here;
                            end else begin
                                depth--;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        pos_now = pos_now + 16'd1;
        if (!fin) return;

        if (first_err == bbc_pkg::ST_OK) begin
            if (in_cmt) begin
                // an open comment only matters while brackets are open
                if (depth != 0) begin
                    first_err = bbc_pkg::ST_UNCLOSED;
                    err_at    = mark_at;
                end
            end else if (in_str) begin
                first_err = bbc_pkg::ST_STRING;
                err_at    = mark_at;
            end else if (depth != 0) begin
                first_err = bbc_pkg::ST_UNCLOSED;
                err_at    = here + 16'd1;
            end
        end
        v.status = first_err;
        v.pos    = (first_err == bbc_pkg::ST_OK) ? 16'd0 : err_at;
        due_verdicts.push_back(v);

        depth       = 0;
        in_str      = 1'b0;
        esc_odd     = 1'b0;
        in_cmt      = 1'b0;
        after_space = 1'b0;
        pos_now     = 16'd0;
        mark_at     = 16'd0;
        first_err   = bbc_pkg::ST_OK;
        err_at      = 16'd0;
    endfunction

    // ------------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] open_char(input logic [1:0] k);
        case (k)
            bbc_pkg::KIND_PAREN:   return bbc_pkg::CH_LPAREN;
            bbc_pkg::KIND_BRACKET: return bbc_pkg::CH_LBRACKET;
            default:               return bbc_pkg::CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] k);
        case (k)
            bbc_pkg::KIND_PAREN:   return bbc_pkg::CH_RPAREN;
            bbc_pkg::KIND_BRACKET: return bbc_pkg::CH_RBRACKET;
            default:               return bbc_pkg::CH_RBRACE;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        string pool = "ab \\/x;=\t";
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic put_byte(input logic [7:0] c, input bit fin);
        text_byte_t b;
        b.ch    = c;
        b.fin   = fin;
        b.gap   = gap_style ? $urandom_range(0, 16) : 0;
        b.drain = drain_next;
        drain_next = 1'b0;
        pending_bytes.push_back(b);
        if (fin) texts_queued++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed texts with strings, escapes and comments mixed in;
    // the rest is left unclosed, has a bracket swapped or is plain noise
    task automatic put_random_text();
        logic [7:0]  body [$];
        logic [1:0]  opened [$];
        string       brackets = "()[]{}";
        int unsigned cap;
        int unsigned pick;
        bit          tidy;
        bit          odd;
        logic [7:0]  c;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            tidy = $urandom_range(0, 9) < 7;
            cap  = ($urandom_range(0, 7) == 0) ? STACK_CAP + 1 : $urandom_range(1, 6);
            // deep texts start near the stack limit
            if (cap > STACK_CAP) begin
                repeat ($urandom_range(STACK_CAP - 2, STACK_CAP)) begin
                    opened.push_back(2'($urandom_range(0, 2)));
                    body.push_back(open_char(opened[$]));
                end
            end
            repeat ($urandom_range(1, 24)) begin
                pick = $urandom_range(0, 9);
                if (pick < 3 && opened.size() < cap) begin
                    opened.push_back(2'($urandom_range(0, 2)));
                    body.push_back(open_char(opened[$]));
                end else if (pick < 6 && opened.size() != 0) begin
                    body.push_back(close_char(opened.pop_back()));
                end else if (pick == 6) begin
                    body.push_back(bbc_pkg::CH_QUOTE);
                    odd = 1'b0;
                    repeat ($urandom_range(0, 5)) begin
                        c = ($urandom_range(0, 2) == 0) ? bbc_pkg::CH_BACKSLASH : plain_char();
                        if (c == bbc_pkg::CH_QUOTE && !odd) c = "a";
                        if ($urandom_range(0, 5) == 0 && odd) c = bbc_pkg::CH_QUOTE;
                        odd = (c == bbc_pkg::CH_BACKSLASH) ? !odd : 1'b0;
                        body.push_back(c);
                    end
                    if (odd) body.push_back(bbc_pkg::CH_BACKSLASH);
                    if (tidy || $urandom_range(0, 2) != 0) body.push_back(bbc_pkg::CH_QUOTE);
                end else if (pick == 7) begin
                    body.push_back(bbc_pkg::CH_SPACE);
                    body.push_back(bbc_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 4)) begin
                        c = plain_char();
                        body.push_back(c == bbc_pkg::CH_NEWLINE ? 8'h78 : c);
                    end
                    if (tidy || $urandom_range(0, 2) != 0) body.push_back(bbc_pkg::CH_NEWLINE);
                end else begin
                    body.push_back(plain_char());
                end
            end
            if (tidy) begin
                while (opened.size() != 0) body.push_back(close_char(opened.pop_back()));
            end else if ($urandom_range(0, 1) != 0) begin
                body[$urandom_range(0, body.size() - 1)] =
                    brackets[$urandom_range(0, brackets.len() - 1)];
            end
        end
        for (int i = 0; i < body.size(); i++) put_byte(body[i], i == body.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // input side: offers queued bytes, feeds accepted ones to the tracker
    // ------------------------------------------------------------------------
    int unsigned gap_left;
    bit          gap_armed;
    bit          offer;
    text_byte_t  nxt;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= 8'h00;
            s_tlast   <= 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_char(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (pending_bytes.size() != 0) begin
                    if (!gap_armed) begin
                        gap_left  = pending_bytes[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!pending_bytes[0].drain || due_verdicts.size() == 0) begin
                        nxt       = pending_bytes.pop_front();
                        offer     = 1'b1;
                        gap_armed = 1'b0;
                        s_tdata   <= nxt.ch;
                        s_tlast   <= nxt.fin;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold, field checks
    // ------------------------------------------------------------------------
    int unsigned   rx_stall;
    bit            rx_calm;
    text_verdict_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_verdicts.size() == 0) begin
                    $display("%0t: result with none due, got status %0d err_pos %0d",
                             $time, m_tdata[2:0], m_tdata[18:3]);
                    errors++;
                end else begin
                    want = due_verdicts.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[18:3] !== want.pos) begin
                        $display("%0t: err_pos expected %0d, got %0d",
                                 $time, want.pos, m_tdata[18:3]);
                        errors++;
                    end
                    if (m_tdata[23:19] !== 5'd0) begin
                        $display("%0t: tdata padding expected 0, got %0h",
                                 $time, m_tdata[23:19]);
                        errors++;
                    end
                end
                results_seen++;
                if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 16);
                // long hold so the block backs up into its input
                if (results_seen == hold_at) rx_stall = 300;
            end else if (rx_stall != 0) begin
                rx_stall--;
            end
            m_tready <= (rx_stall == 0);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    int unsigned random_from;
    int unsigned burst_len;
    string       burst_pool = "(){}[]a \"";

    initial begin
        gap_style = 1'b1;
        put_text("(");                  // bracket open at the end
        put_text("[}");                 // wrong kind of close
        put_text("\"\\\"");             // escaped quote leaves the string open
        put_text("\"\\\\\"");           // escaped backslash, string closes
        put_text("( /\n)");             // comment ends at the newline
        put_text("( /");                // comment open with a bracket open
        put_text(" /x");                // comment open, nothing open
        put_byte(bbc_pkg::CH_RPAREN, 1'b0);  // close on empty stack, then only counting
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        repeat (STACK_CAP - 1) put_byte(bbc_pkg::CH_LBRACE, 1'b0);
        put_byte(bbc_pkg::CH_LPAREN, 1'b1);  // one push too many

        // back-to-back short texts against a held result side
        gap_style  = 1'b0;
        hold_at    = texts_queued;
        drain_next = 1'b1;
        repeat (40) begin
            burst_len = $urandom_range(1, 3);
            for (int i = 0; i < burst_len; i++) begin
                put_byte(burst_pool[$urandom_range(0, burst_pool.len() - 1)],
                         i == burst_len - 1);
            end
        end

        gap_style   = 1'b1;
        random_from = pending_bytes.size();
        while (pending_bytes.size() < random_from + 1500) begin
            if ($urandom_range(0, 7) == 0) gap_style = !gap_style;
            if (texts_queued % 25 == 0) drain_next = 1'b1;
            put_random_text();
        end
        bytes_total = pending_bytes.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_sent < bytes_total || due_verdicts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog that ends a run that hangs
    initial begin
        #4_800_000;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
